FILE: rtl/psce_pkg.sv
// Package for the pairwise scale change estimator.
// Holds the sequencer states, register indexes and fixed widths.
// No dependencies.
package psce_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned ScaleW = 15;
  localparam int unsigned SumW   = 40;
  localparam int unsigned DistW  = 17;
  localparam int unsigned RadW   = 33;
  localparam int unsigned QuotW  = SumW + 14;

  localparam logic [ScaleW-1:0] ScaleOne  = 15'd16384;
  localparam logic [ScaleW-1:0] CountMax  = 15'd32767;

  localparam logic [1:0] RegLowBound  = 2'd0;
  localparam logic [1:0] RegHighBound = 2'd1;
  localparam logic [1:0] RegMinPairs  = 2'd2;

  typedef enum logic [3:0] {
    StLoad,
    StIRd,
    StILat,
    StJRd,
    StJLat,
    StMulX,
    StMulY,
    StSqGo,
    StSqWait,
    StNextJ,
    StNextI,
    StDivGo,
    StDivRun,
    StOut
  } state_e;

endpackage

FILE: rtl/pairwise_scale_change_estimator.sv
// Top level of the pairwise scale change estimator.
// Depends on psce_pkg and psce_sqrt.
//
// Corners arrive as transfers on the slave stream: tdata carries the previous
// and current positions, tuser the outlier mark and tlast the last corner of
// a frame. Each corner taken is stored in on-chip memory; corners beyond
// MAX_CORNERS are dropped. A transfer with tlast starts the walk over every
// pair of stored non-outlier corners, during which s_axis_tready is low.
// Each pair uses the shared squarer and the bit-serial square root, run
// twice per pair, once for each frame; a pair with zero previous distance
// skips the second run, and a pair with an outlier partner is skipped. A
// final bit-serial division forms the ratio when the checks need it.
// The single result transfer then sits in an output register on the master
// stream until it is taken; a stalled receiver holds the block in that state
// and no new corner is taken.
// Reset clears the sequencer, the corner count and the registers to their
// defaults; the corner memories need no clearing pass.
module pairwise_scale_change_estimator #(
  parameter int unsigned MAX_CORNERS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // prev_x, prev_y, cur_x, cur_y
  input  logic [63:0] s_axis_tdata,
  // is_outlier
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scale_change, pair_count, two zero bits
  output logic [31:0] m_axis_tdata,
  // estimate_accepted
  output logic        m_axis_tuser
);

  localparam int unsigned AW = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1;
  localparam int unsigned CW = $clog2(MAX_CORNERS + 1);

  psce_pkg::state_e state_q, state_d;

  logic [31:0] prev_mem [MAX_CORNERS];
  logic [31:0] cur_mem  [MAX_CORNERS];
  logic        out_mem  [MAX_CORNERS];
  logic [31:0] rd_prev_q, rd_cur_q;
  logic        rd_out_q;
  logic [AW-1:0] rd_addr;

  logic [CW-1:0] cnt_q, n_q;
  logic [AW-1:0] i_q, j_q;
  logic [31:0]   ai_prev_q, ai_cur_q, b_prev_q, b_cur_q;
  logic          phase_q;
  logic [psce_pkg::RadW-1:0]   sq_q;
  logic [psce_pkg::DistW-1:0]  dp_q;
  logic [psce_pkg::SumW-1:0]   sum_prev_q, sum_cur_q, rem_q;
  logic [psce_pkg::QuotW-1:0]  dq_q;
  logic [5:0]                  div_cnt_q;
  logic [psce_pkg::ScaleW-1:0] pairs_q, low_q, high_q, minp_q;
  logic [psce_pkg::ScaleW-1:0] scale_o_q, pairs_o_q;
  logic                        acc_o_q;

  logic        in_xfer, last_in;
  logic        sq_start, sq_done;
  logic [psce_pkg::DistW-1:0] root;
  logic [31:0] pa, pb;
  logic [15:0] dx, dy, mop;
  logic [31:0] prod;
  logic [psce_pkg::SumW:0] add_prev, add_cur;
  logic [psce_pkg::SumW:0] rem_sh;
  logic        div_ge;
  logic [CW-1:0] cnt_new;
  logic [CW-1:0] j_inc, i_inc2;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign last_in  = in_xfer && s_axis_tlast;
  assign cnt_new  = (cnt_q < CW'(MAX_CORNERS)) ? cnt_q + CW'(1) : cnt_q;
  assign j_inc    = CW'(j_q) + CW'(1);
  assign i_inc2   = CW'(i_q) + CW'(2);

  assign pa   = phase_q ? ai_cur_q : ai_prev_q;
  assign pb   = phase_q ? b_cur_q  : b_prev_q;
  assign dx   = (pa[15:0] > pb[15:0]) ? pa[15:0] - pb[15:0] : pb[15:0] - pa[15:0];
  assign dy   = (pa[31:16] > pb[31:16]) ? pa[31:16] - pb[31:16] : pb[31:16] - pa[31:16];
  assign mop  = (state_q == psce_pkg::StMulX) ? dx : dy;
  assign prod = mop * mop;

  assign add_prev = {1'b0, sum_prev_q} + (psce_pkg::SumW+1)'(dp_q);
  assign add_cur  = {1'b0, sum_cur_q} + (psce_pkg::SumW+1)'(root);
  assign rem_sh   = {rem_q, dq_q[psce_pkg::QuotW-1]};
  assign div_ge   = rem_sh >= {1'b0, sum_prev_q};

  psce_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .rad_i  (sq_q),
    .done_o (sq_done),
    .root_o (root)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      psce_pkg::StLoad: begin
        if (last_in) begin
          state_d = (cnt_new >= CW'(2)) ? psce_pkg::StIRd : psce_pkg::StOut;
        end
      end
      psce_pkg::StIRd:  state_d = psce_pkg::StILat;
      psce_pkg::StILat: state_d = rd_out_q ? psce_pkg::StNextI : psce_pkg::StJRd;
      psce_pkg::StJRd:  state_d = psce_pkg::StJLat;
      psce_pkg::StJLat: state_d = rd_out_q ? psce_pkg::StNextJ : psce_pkg::StMulX;
      psce_pkg::StMulX: state_d = psce_pkg::StMulY;
      psce_pkg::StMulY: state_d = psce_pkg::StSqGo;
      psce_pkg::StSqGo: state_d = psce_pkg::StSqWait;
      psce_pkg::StSqWait: begin
        if (sq_done) begin
          if (phase_q || root == '0) begin
            state_d = psce_pkg::StNextJ;
          end else begin
            state_d = psce_pkg::StMulX;
          end
        end
      end
      psce_pkg::StNextJ: state_d = (j_inc < n_q) ? psce_pkg::StJRd : psce_pkg::StNextI;
      psce_pkg::StNextI: state_d = (i_inc2 < n_q) ? psce_pkg::StIRd : psce_pkg::StDivGo;
      psce_pkg::StDivGo: begin
        state_d = (sum_prev_q != '0 && pairs_q > minp_q) ? psce_pkg::StDivRun
                                                         : psce_pkg::StOut;
      end
      psce_pkg::StDivRun: begin
        if (div_cnt_q == 6'(psce_pkg::QuotW)) state_d = psce_pkg::StOut;
      end
      psce_pkg::StOut: if (m_axis_tready) state_d = psce_pkg::StLoad;
      default: state_d = psce_pkg::StLoad;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == psce_pkg::StLoad);
    m_axis_tvalid = (state_q == psce_pkg::StOut);
    sq_start      = (state_q == psce_pkg::StSqGo);
    rd_addr       = (state_q == psce_pkg::StIRd) ? i_q : j_q;
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && cnt_q < CW'(MAX_CORNERS)) begin
      prev_mem[cnt_q[AW-1:0]] <= s_axis_tdata[31:0];
      cur_mem[cnt_q[AW-1:0]]  <= s_axis_tdata[63:32];
      out_mem[cnt_q[AW-1:0]]  <= s_axis_tuser;
    end
    rd_prev_q <= prev_mem[rd_addr];
    rd_cur_q  <= cur_mem[rd_addr];
    rd_out_q  <= out_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= psce_pkg::StLoad;
      cnt_q      <= '0;
      sum_prev_q <= '0;
      sum_cur_q  <= '0;
      low_q      <= 15'd13107;
      high_q     <= 15'd19661;
      minp_q     <= 15'd5;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          psce_pkg::RegLowBound:  low_q  <= cfg_data_i;
          psce_pkg::RegHighBound: high_q <= cfg_data_i;
          psce_pkg::RegMinPairs:  minp_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_xfer) begin
        cnt_q <= s_axis_tlast ? '0 : cnt_new;
        if (s_axis_tlast) begin
          sum_prev_q <= '0;
          sum_cur_q  <= '0;
        end
      end
      if (state_q == psce_pkg::StSqWait && sq_done && phase_q) begin
        sum_prev_q <= add_prev[psce_pkg::SumW] ? '1 : add_prev[psce_pkg::SumW-1:0];
        sum_cur_q  <= add_cur[psce_pkg::SumW] ? '1 : add_cur[psce_pkg::SumW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      psce_pkg::StLoad: begin
        n_q       <= cnt_new;
        i_q       <= '0;
        pairs_q   <= '0;
        scale_o_q <= psce_pkg::ScaleOne;
        acc_o_q   <= 1'b0;
        pairs_o_q <= '0;
      end
      psce_pkg::StILat: begin
        ai_prev_q <= rd_prev_q;
        ai_cur_q  <= rd_cur_q;
        j_q       <= AW'(CW'(i_q) + CW'(1));
      end
      psce_pkg::StJLat: begin
        b_prev_q <= rd_prev_q;
        b_cur_q  <= rd_cur_q;
        phase_q  <= 1'b0;
      end
      psce_pkg::StMulX: sq_q <= {1'b0, prod};
      psce_pkg::StMulY: sq_q <= sq_q + {1'b0, prod};
      psce_pkg::StSqWait: begin
        if (sq_done) begin
          if (!phase_q) begin
            dp_q    <= root;
            phase_q <= 1'b1;
          end else if (pairs_q != psce_pkg::CountMax) begin
            pairs_q <= pairs_q + 15'd1;
          end
        end
      end
      psce_pkg::StNextJ: j_q <= AW'(j_inc);
      psce_pkg::StNextI: i_q <= AW'(CW'(i_q) + CW'(1));
      psce_pkg::StDivGo: begin
        dq_q      <= {sum_cur_q, 14'd0};
        rem_q     <= '0;
        div_cnt_q <= '0;
        pairs_o_q <= pairs_q;
      end
      psce_pkg::StDivRun: begin
        if (div_cnt_q == 6'(psce_pkg::QuotW)) begin
          if (dq_q > (psce_pkg::QuotW)'(low_q) && dq_q < (psce_pkg::QuotW)'(high_q)) begin
            scale_o_q <= dq_q[psce_pkg::ScaleW-1:0];
            acc_o_q   <= 1'b1;
          end
        end else begin
          rem_q     <= div_ge ? rem_sh[psce_pkg::SumW-1:0] - sum_prev_q
                              : rem_sh[psce_pkg::SumW-1:0];
          dq_q      <= {dq_q[psce_pkg::QuotW-2:0], div_ge};
          div_cnt_q <= div_cnt_q + 6'd1;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = {2'b00, pairs_o_q, scale_o_q};
  assign m_axis_tuser = acc_o_q;

endmodule

FILE: rtl/psce_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on psce_pkg for widths.
module psce_sqrt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [psce_pkg::RadW-1:0]        rad_i,
  output logic                             done_o,
  output logic [psce_pkg::DistW-1:0]       root_o
);

  logic [33:0]                  rad_q, rad_d;
  logic [19:0]                  rem_q, rem_d;
  logic [psce_pkg::DistW-1:0]   root_q, root_d;
  logic [4:0]                   cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [19:0]                  rem_sh;
  logic [19:0]                  trial;

  assign rem_sh = {rem_q[17:0], rad_q[33:32]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = {1'b0, rad_i};
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[31:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[psce_pkg::DistW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[psce_pkg::DistW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(psce_pkg::DistW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
